>>> rtl/cch_pkg.sv
// Package for the compass calibration and heading block.
// Holds the word types of both channels, the queue word, codes and the CORDIC angle table.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package cch_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int DIFF_WIDTH     = SAMPLE_WIDTH + 1;
   localparam int PRESCALE_SHIFT = 24;
   // Room for the prescaled difference and the CORDIC gain.
   localparam int VEC_WIDTH      = DIFF_WIDTH + PRESCALE_SHIFT + 3;
   localparam int ANG_WIDTH      = 33;
   localparam int ANG_FRAC       = 16;
   localparam int HEAD_WIDTH     = 16;
   localparam int MAX_STEPS      = 24;
   localparam int CSR_IDX_WIDTH  = 2;

   localparam logic signed [HEAD_WIDTH-1:0] HALF_TURN    = 16'sd18000;
   localparam logic signed [HEAD_WIDTH-1:0] FAIL_HEADING = 16'sd18100;
   localparam logic signed [ANG_WIDTH-1:0]  TURN_SCALED  = 33'sd1179648000;
   localparam logic signed [ANG_WIDTH-1:0]  ROUND_HALF   = 33'sd32768;

   // Actions carried by an input word.
   localparam logic [1:0] ACT_CAL_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_END_CAL    = 2'd1;
   localparam logic [1:0] ACT_HEADING    = 2'd2;
   localparam logic [1:0] ACT_RESTORE    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_STORED_X       = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_STORED_Y       = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_STORED_Z       = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_STORED_PRESENT = 2'd3;

   // What the back end has to produce for a queued word.
   localparam logic [1:0] JOB_NONE  = 2'd0;
   localparam logic [1:0] JOB_FAIL  = 2'd1;
   localparam logic [1:0] JOB_ANGLE = 2'd2;

   typedef struct packed {
      logic [1:0]                     action;
      logic signed [SAMPLE_WIDTH-1:0] x_sample;
      logic signed [SAMPLE_WIDTH-1:0] y_sample;
      logic signed [SAMPLE_WIDTH-1:0] z_sample;
      logic                           read_ok;
   } req_type;

   typedef struct packed {
      logic signed [HEAD_WIDTH-1:0]   heading_centideg;
      logic                           heading_valid;
      logic                           calibrated;
      logic signed [SAMPLE_WIDTH-1:0] x_offset;
      logic signed [SAMPLE_WIDTH-1:0] y_offset;
      logic signed [SAMPLE_WIDTH-1:0] z_offset;
      logic                           accepted;
   } rsp_type;

   // Status that rides alongside the angle computation.
   typedef struct packed {
      logic [1:0]                     kind;
      logic                           calibrated;
      logic signed [SAMPLE_WIDTH-1:0] x_offset;
      logic signed [SAMPLE_WIDTH-1:0] y_offset;
      logic signed [SAMPLE_WIDTH-1:0] z_offset;
      logic                           accepted;
   } side_type;

   typedef struct packed {
      side_type                       side;
      logic signed [DIFF_WIDTH-1:0]   num;
      logic signed [DIFF_WIDTH-1:0]   den;
   } job_type;

   // atan(2^-i) in centidegrees scaled by 2^16, rounded.
   function automatic logic [31:0] atan_step(input int unsigned idx);
      logic [31:0] val;
      unique case (idx)
         0:  val = 32'd294912000;
         1:  val = 32'd174096719;
         2:  val = 32'd91987925;
         3:  val = 32'd46694507;
         4:  val = 32'd23437865;
         5:  val = 32'd11730358;
         6:  val = 32'd5866610;
         7:  val = 32'd2933484;
         8:  val = 32'd1466764;
         9:  val = 32'd733385;
         10: val = 32'd366693;
         11: val = 32'd183346;
         12: val = 32'd91673;
         13: val = 32'd45837;
         14: val = 32'd22918;
         15: val = 32'd11459;
         16: val = 32'd5730;
         17: val = 32'd2865;
         18: val = 32'd1432;
         19: val = 32'd716;
         20: val = 32'd358;
         21: val = 32'd179;
         22: val = 32'd90;
         23: val = 32'd45;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> rtl/compass_calibrate_and_heading.sv
// Compass hard-iron calibration and heading, top level.
// Path: the queue, the CORDIC entry stage, one stage per iteration, then the result register.
// Throughput: one word per cycle unless a held result stalls the pipeline; set by the CORDIC pipeline.
// Reset clears extremes, offsets, stored registers, the queue and all valid flags.
// Depends on cch_pkg, cch_front, cch_queue and cch_back.
`default_nettype none

module compass_calibrate_and_heading #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  cch_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output cch_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [cch_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire [cch_pkg::SAMPLE_WIDTH-1:0]     csr_data
);

   logic             push_valid, push_ready;
   cch_pkg::job_type push_job;
   logic             pop_valid, pop_ready;
   cch_pkg::job_type pop_job;

   assign csr_ready = 1'b1;

   cch_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   cch_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   cch_back #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // No word may leave the result register in the cycle after a reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // A computed heading is always an accepted one and lies within a half turn.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.heading_valid) |->
         (rsp_data.accepted &&
          rsp_data.heading_centideg <= cch_pkg::HALF_TURN &&
          rsp_data.heading_centideg >= -cch_pkg::HALF_TURN))
      else $error("heading out of range or not accepted");

   // Without a computed heading the field is either zero or the failed-read mark.
   a_heading_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.heading_valid && rsp_data.heading_centideg != '0) |->
         (rsp_data.heading_centideg == cch_pkg::FAIL_HEADING && !rsp_data.accepted))
      else $error("unexpected heading value without a valid heading");

endmodule

`default_nettype wire

>>> rtl/cch_front.sv
// Front end: accepts input words, keeps the calibration state and the stored offsets,
// and hands one job word per input to the queue. Depends on cch_pkg.
`default_nettype none

module cch_front (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  cch_pkg::req_type                       req_data,
   input  wire                                    csr_valid,
   input  wire [cch_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  wire [cch_pkg::SAMPLE_WIDTH-1:0]        csr_data,
   input  wire                                    push_ready,
   output logic                                   push_valid,
   output cch_pkg::job_type                       push_job
);

   localparam int SW = cch_pkg::SAMPLE_WIDTH;
   localparam int DW = cch_pkg::DIFF_WIDTH;
   localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

   logic signed [SW-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff, min_z_ff, max_z_ff;
   logic signed [SW-1:0] min_x_in, max_x_in, min_y_in, max_y_in, min_z_in, max_z_in;
   logic signed [SW-1:0] x_off_ff, y_off_ff, z_off_ff;
   logic signed [SW-1:0] x_off_in, y_off_in, z_off_in;
   logic                 cal_done_ff, cal_done_in;
   logic signed [SW-1:0] st_x_ff, st_y_ff, st_z_ff;
   logic                 st_present_ff;
   logic                 accept;
   logic                 acc;
   logic [1:0]           kind;

   function automatic logic signed [SW-1:0] midpoint(input logic signed [SW-1:0] lo,
                                                     input logic signed [SW-1:0] hi);
      logic signed [SW:0] sum;
      logic signed [SW:0] adj;
      sum = {lo[SW-1], lo} + {hi[SW-1], hi};
      // Adding the sign bit before the shift rounds toward zero.
      adj = sum + {{SW{1'b0}}, sum[SW]};
      return adj[SW:1];
   endfunction

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = accept;

   always_comb begin
      min_x_in    = min_x_ff;
      max_x_in    = max_x_ff;
      min_y_in    = min_y_ff;
      max_y_in    = max_y_ff;
      min_z_in    = min_z_ff;
      max_z_in    = max_z_ff;
      x_off_in    = x_off_ff;
      y_off_in    = y_off_ff;
      z_off_in    = z_off_ff;
      cal_done_in = cal_done_ff;
      acc         = 1'b0;
      kind        = cch_pkg::JOB_NONE;
      unique case (req_data.action)
         cch_pkg::ACT_CAL_SAMPLE: begin
            if (req_data.read_ok) begin
               if (req_data.x_sample < min_x_ff) min_x_in = req_data.x_sample;
               if (req_data.x_sample > max_x_ff) max_x_in = req_data.x_sample;
               if (req_data.y_sample < min_y_ff) min_y_in = req_data.y_sample;
               if (req_data.y_sample > max_y_ff) max_y_in = req_data.y_sample;
               if (req_data.z_sample < min_z_ff) min_z_in = req_data.z_sample;
               if (req_data.z_sample > max_z_ff) max_z_in = req_data.z_sample;
               acc = 1'b1;
            end
         end
         cch_pkg::ACT_END_CAL: begin
            x_off_in    = midpoint(min_x_ff, max_x_ff);
            y_off_in    = midpoint(min_y_ff, max_y_ff);
            z_off_in    = midpoint(min_z_ff, max_z_ff);
            cal_done_in = 1'b1;
            acc         = 1'b1;
         end
         cch_pkg::ACT_HEADING: begin
            acc  = req_data.read_ok;
            kind = req_data.read_ok ? cch_pkg::JOB_ANGLE : cch_pkg::JOB_FAIL;
         end
         cch_pkg::ACT_RESTORE: begin
            if (st_present_ff) begin
               x_off_in    = st_x_ff;
               y_off_in    = st_y_ff;
               z_off_in    = st_z_ff;
               cal_done_in = 1'b1;
               acc         = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      push_job.side.kind       = kind;
      push_job.side.calibrated = cal_done_in;
      push_job.side.x_offset   = x_off_in;
      push_job.side.y_offset   = y_off_in;
      push_job.side.z_offset   = z_off_in;
      push_job.side.accepted   = acc;
      push_job.num = {req_data.x_sample[SW-1], req_data.x_sample} - {x_off_ff[SW-1], x_off_ff};
      push_job.den = {req_data.y_sample[SW-1], req_data.y_sample} - {y_off_ff[SW-1], y_off_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff    <= SMAX;
         min_y_ff    <= SMAX;
         min_z_ff    <= SMAX;
         max_x_ff    <= SMIN;
         max_y_ff    <= SMIN;
         max_z_ff    <= SMIN;
         x_off_ff    <= '0;
         y_off_ff    <= '0;
         z_off_ff    <= '0;
         cal_done_ff <= 1'b0;
      end else if (accept) begin
         min_x_ff    <= min_x_in;
         min_y_ff    <= min_y_in;
         min_z_ff    <= min_z_in;
         max_x_ff    <= max_x_in;
         max_y_ff    <= max_y_in;
         max_z_ff    <= max_z_in;
         x_off_ff    <= x_off_in;
         y_off_ff    <= y_off_in;
         z_off_ff    <= z_off_in;
         cal_done_ff <= cal_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_x_ff       <= '0;
         st_y_ff       <= '0;
         st_z_ff       <= '0;
         st_present_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            cch_pkg::REG_STORED_X:       st_x_ff       <= csr_data;
            cch_pkg::REG_STORED_Y:       st_y_ff       <= csr_data;
            cch_pkg::REG_STORED_Z:       st_z_ff       <= csr_data;
            cch_pkg::REG_STORED_PRESENT: st_present_ff <= csr_data[0];
         endcase
      end
   end

   // The difference width must cover a sample minus an offset.
   if (DW != SW + 1) begin : g_bad_width
      $error("difference width mismatch");
   end

endmodule

`default_nettype wire

>>> rtl/cch_queue.sv
// Two-entry queue of job words between the front end and the CORDIC back end.
// Depends on cch_pkg for the job word type.
`default_nettype none

module cch_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  cch_pkg::job_type  push_job,
   output logic              pop_valid,
   input  wire               pop_ready,
   output cch_pkg::job_type  pop_job
);

   cch_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

>>> rtl/cch_back.sv
// Back end: folding entry stage, vectoring CORDIC pipeline, one register stage per
// iteration, then the rounding, clamping and result register. Depends on cch_pkg.
`default_nettype none

module cch_back #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               job_valid,
   output logic              job_ready,
   input  cch_pkg::job_type  job,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output cch_pkg::rsp_type  rsp_data
);

   localparam int N  = CORDIC_ITERATIONS;
   localparam int VW = cch_pkg::VEC_WIDTH;
   localparam int AW = cch_pkg::ANG_WIDTH;
   localparam int DW = cch_pkg::DIFF_WIDTH;
   localparam int PS = cch_pkg::PRESCALE_SHIFT;
   localparam int HW = cch_pkg::HEAD_WIDTH;
   localparam int RW = AW - cch_pkg::ANG_FRAC;

   logic signed [VW-1:0] vx_ff [N+1];
   logic signed [VW-1:0] vy_ff [N+1];
   logic signed [AW-1:0] ang_ff [N+1];
   logic                 zero_ff [N+1];
   cch_pkg::side_type    side_ff [N+1];
   logic                 vld_ff [N+1];

   cch_pkg::rsp_type     out_ff, out_in;
   logic                 out_valid_ff;
   logic                 adv;

   logic signed [VW-1:0] num_s, den_s;
   logic signed [AW-1:0] ang_sum;
   logic signed [RW-1:0] ang_round;
   logic signed [HW-1:0] ang_clamp;

   // The whole pipeline moves together whenever the result register can take a word.
   assign adv       = !out_valid_ff || rsp_ready;
   assign job_ready = adv;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign num_s = {{(VW-DW-PS){job.num[DW-1]}}, job.num, {PS{1'b0}}};
   assign den_s = {{(VW-DW-PS){job.den[DW-1]}}, job.den, {PS{1'b0}}};

   // Entry stage: fold the left half plane onto the right one.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= job.side;
         zero_ff[0] <= (job.num == '0) && (job.den == '0);
         if (den_s[VW-1]) begin
            vx_ff[0]  <= -den_s;
            vy_ff[0]  <= -num_s;
            ang_ff[0] <= num_s[VW-1] ? -cch_pkg::TURN_SCALED : cch_pkg::TURN_SCALED;
         end else begin
            vx_ff[0]  <= den_s;
            vy_ff[0]  <= num_s;
            ang_ff[0] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= job_valid;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_iter
      logic signed [VW-1:0] dx, dy;
      logic signed [AW-1:0] step;

      assign dx   = vy_ff[k] >>> k;
      assign dy   = vx_ff[k] >>> k;
      assign step = $signed({1'b0, cch_pkg::atan_step(k)});

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= side_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            if (!vy_ff[k][VW-1]) begin
               vx_ff[k+1]  <= vx_ff[k] + dx;
               vy_ff[k+1]  <= vy_ff[k] - dy;
               ang_ff[k+1] <= ang_ff[k] + step;
            end else begin
               vx_ff[k+1]  <= vx_ff[k] - dx;
               vy_ff[k+1]  <= vy_ff[k] + dy;
               ang_ff[k+1] <= ang_ff[k] - step;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   // Round to the nearest centidegree by flooring after adding one half.
   always_comb begin
      ang_sum   = ang_ff[N] + cch_pkg::ROUND_HALF;
      ang_round = ang_sum[AW-1:cch_pkg::ANG_FRAC];
      if (ang_round > RW'(cch_pkg::HALF_TURN)) begin
         ang_clamp = cch_pkg::HALF_TURN;
      end else if (ang_round < -RW'(cch_pkg::HALF_TURN)) begin
         ang_clamp = -cch_pkg::HALF_TURN;
      end else begin
         ang_clamp = ang_round[HW-1:0];
      end
   end

   always_comb begin
      out_in.heading_valid = 1'b0;
      unique case (side_ff[N].kind)
         cch_pkg::JOB_ANGLE: begin
            out_in.heading_centideg = zero_ff[N] ? '0 : ang_clamp;
            out_in.heading_valid    = 1'b1;
         end
         cch_pkg::JOB_FAIL: out_in.heading_centideg = cch_pkg::FAIL_HEADING;
         default:           out_in.heading_centideg = '0;
      endcase
      out_in.calibrated = side_ff[N].calibrated;
      out_in.x_offset   = side_ff[N].x_offset;
      out_in.y_offset   = side_ff[N].y_offset;
      out_in.z_offset   = side_ff[N].z_offset;
      out_in.accepted   = side_ff[N].accepted;
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= vld_ff[N];
      end
   end

endmodule

`default_nettype wire

>>> tb/cch_status_checker.sv
`timescale 1ns / 100ps
// Checker for the compass calibration and heading block: watches all three channels,
// keeps its own copy of extremes, offsets and stored registers, and compares every status word.
// Depends on cch_pkg for the word types, action codes and register indexes.

module cch_status_checker #(
   parameter int ITERATIONS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  cch_pkg::req_type                 req_data,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  cch_pkg::rsp_type                 rsp_data,
   input  wire                              csr_valid,
   input  wire                              csr_ready,
   input  wire [cch_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire [cch_pkg::SAMPLE_WIDTH-1:0]  csr_data,
   output int                               mismatches,
   output int                               outstanding
);

   localparam longint PRESCALE   = 64'sd16777216;
   localparam longint HALF_CDEG  = 64'sd18000;
   localparam longint ROUND_BIAS = 64'sd32768;

   // atan(2^-k) in centidegrees, 16 fractional bits.
   longint atan_cdeg [0:23] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45};

   logic signed [15:0] min_x, max_x, min_y, max_y, min_z, max_z;
   logic signed [15:0] off_x, off_y, off_z;
   logic               cal_done;
   logic signed [15:0] saved_x, saved_y, saved_z;
   logic               saved_present;
   cch_pkg::rsp_type   status_due [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic logic signed [15:0] cordic_centideg(input longint num, input longint den);
      longint vx, vy, ang, dx, dy, r;
      int     steps;
      if (num == 0 && den == 0) return 16'sd0;
      vx  = den * PRESCALE;
      vy  = num * PRESCALE;
      ang = 0;
      // Vectors in the left half plane are folded over and start half a turn round.
      if (vx < 0) begin
         ang = (vy >= 0) ? HALF_CDEG * 65536 : -HALF_CDEG * 65536;
         vx  = -vx;
         vy  = -vy;
      end
      steps = (ITERATIONS > 24) ? 24 : ITERATIONS;
      for (int k = 0; k < steps; k++) begin
         dx = vy >>> k;
         dy = vx >>> k;
         if (vy >= 0) begin
            vx  = vx + dx;
            vy  = vy - dy;
            ang = ang + atan_cdeg[k];
         end else begin
            vx  = vx - dx;
            vy  = vy + dy;
            ang = ang - atan_cdeg[k];
         end
      end
      r = (ang + ROUND_BIAS) >>> 16;
      if (r > HALF_CDEG) r = HALF_CDEG;
      if (r < -HALF_CDEG) r = -HALF_CDEG;
      return 16'(r);
   endfunction

   function automatic cch_pkg::rsp_type advance_compass(input cch_pkg::req_type w);
      cch_pkg::rsp_type r;
      r = '0;
      case (w.action)
         cch_pkg::ACT_CAL_SAMPLE: begin
            if (w.read_ok) begin
               if (w.x_sample < min_x) min_x = w.x_sample;
               if (w.x_sample > max_x) max_x = w.x_sample;
               if (w.y_sample < min_y) min_y = w.y_sample;
               if (w.y_sample > max_y) max_y = w.y_sample;
               if (w.z_sample < min_z) min_z = w.z_sample;
               if (w.z_sample > max_z) max_z = w.z_sample;
               r.accepted = 1'b1;
            end
         end
         cch_pkg::ACT_END_CAL: begin
            // Integer division truncates toward zero, as the midpoint requires.
            off_x      = 16'((int'(max_x) + int'(min_x)) / 2);
            off_y      = 16'((int'(max_y) + int'(min_y)) / 2);
            off_z      = 16'((int'(max_z) + int'(min_z)) / 2);
            cal_done   = 1'b1;
            r.accepted = 1'b1;
         end
         cch_pkg::ACT_HEADING: begin
            if (w.read_ok) begin
               r.heading_centideg = cordic_centideg(
                  longint'(w.x_sample) - longint'(off_x),
                  longint'(w.y_sample) - longint'(off_y));
               r.heading_valid = 1'b1;
               r.accepted      = 1'b1;
            end else begin
               r.heading_centideg = cch_pkg::FAIL_HEADING;
            end
         end
         cch_pkg::ACT_RESTORE: begin
            if (saved_present) begin
               off_x      = saved_x;
               off_y      = saved_y;
               off_z      = saved_z;
               cal_done   = 1'b1;
               r.accepted = 1'b1;
            end
         end
      endcase
      r.calibrated = cal_done;
      r.x_offset   = off_x;
      r.y_offset   = off_y;
      r.z_offset   = off_z;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t: status mismatch on %s: got %0d, expected %0d", $realtime, what, got,
               want);
   endtask

   always @(posedge clock) begin : watch
      cch_pkg::rsp_type want;
      if (reset) begin
         min_x = 16'sh7fff;  min_y = 16'sh7fff;  min_z = 16'sh7fff;
         max_x = -16'sh8000; max_y = -16'sh8000; max_z = -16'sh8000;
         off_x = '0; off_y = '0; off_z = '0;
         cal_done      = 1'b0;
         saved_x       = '0;
         saved_y       = '0;
         saved_z       = '0;
         saved_present = 1'b0;
         status_due.delete();
      end else begin
         // Results are taken before new words, since a word never comes back in its own cycle.
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               note_mismatch("word with nothing awaited", 1, 0);
            end else begin
               want = status_due.pop_front();
               if (rsp_data.heading_centideg !== want.heading_centideg)
                  note_mismatch("heading_centideg", rsp_data.heading_centideg,
                                want.heading_centideg);
               if (rsp_data.heading_valid !== want.heading_valid)
                  note_mismatch("heading_valid", rsp_data.heading_valid, want.heading_valid);
               if (rsp_data.calibrated !== want.calibrated)
                  note_mismatch("calibrated", rsp_data.calibrated, want.calibrated);
               if (rsp_data.x_offset !== want.x_offset)
                  note_mismatch("x_offset", rsp_data.x_offset, want.x_offset);
               if (rsp_data.y_offset !== want.y_offset)
                  note_mismatch("y_offset", rsp_data.y_offset, want.y_offset);
               if (rsp_data.z_offset !== want.z_offset)
                  note_mismatch("z_offset", rsp_data.z_offset, want.z_offset);
               if (rsp_data.accepted !== want.accepted)
                  note_mismatch("accepted", rsp_data.accepted, want.accepted);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cch_pkg::REG_STORED_X:       saved_x       = csr_data;
               cch_pkg::REG_STORED_Y:       saved_y       = csr_data;
               cch_pkg::REG_STORED_Z:       saved_z       = csr_data;
               cch_pkg::REG_STORED_PRESENT: saved_present = csr_data[0];
            endcase
         end
         if (req_valid && req_ready)
            status_due.push_back(advance_compass(req_data));
      end
      outstanding = status_due.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for the compass calibration and heading block.
// Drives sample words and register writes, stalls the result side, and gives the verdict.
// Depends on cch_pkg, the block itself and cch_status_checker.

module tb;

   localparam int CORDIC_STEPS = 16;
   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = 165;
   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   cch_pkg::req_type                  req_data;
   logic                              rsp_valid;
   logic                              rsp_ready;
   cch_pkg::rsp_type                  rsp_data;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [cch_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [cch_pkg::SAMPLE_WIDTH-1:0]  csr_data;

   int mismatches;
   int outstanding;
   int sent;
   int quiet_cycles;
   bit jitter_on;
   bit hold_output;

   compass_calibrate_and_heading #(
      .CORDIC_ITERATIONS (CORDIC_STEPS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   cch_status_checker #(
      .ITERATIONS (CORDIC_STEPS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = cch_pkg::REG_STORED_X;
      csr_data    = '0;
      sent        = 0;
      jitter_on   = 1'b1;
      hold_output = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Result side: random back-pressure, plus one long hold when the stimulus asks for it.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else begin
            rsp_ready <= !(jitter_on && $urandom_range(99) < 6);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic int any16();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int jitter_around(input int centre, input int spread);
      return centre + int'($urandom_range(2 * spread)) - spread;
   endfunction

   function automatic logic signed [15:0] clamp16(input int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return 16'(v);
   endfunction

   function automatic cch_pkg::req_type make_word(input logic [1:0] act, input int x,
                                                  input int y, input int z, input logic ok);
      cch_pkg::req_type w;
      w.action   = act;
      w.x_sample = clamp16(x);
      w.y_sample = clamp16(y);
      w.z_sample = clamp16(z);
      w.read_ok  = ok;
      return w;
   endfunction

   // Valid is left high after acceptance; the next falling edge either replaces the word
   // or lowers valid, so it is never dropped and raised in the same step.
   task automatic push_req(input cch_pkg::req_type w);
      @(negedge clock);
      while (jitter_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic put_reg(input logic [cch_pkg::CSR_IDX_WIDTH-1:0] idx,
                          input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Registers are only touched once every outstanding status word has come back.
   task automatic write_settings(input int sx, input int sy, input int sz, input logic present);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      put_reg(cch_pkg::REG_STORED_X, clamp16(sx));
      put_reg(cch_pkg::REG_STORED_Y, clamp16(sy));
      put_reg(cch_pkg::REG_STORED_Z, clamp16(sz));
      put_reg(cch_pkg::REG_STORED_PRESENT, 16'(present));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One burst of traffic: mostly a calibration run followed by headings, sometimes a
   // restore in place of the run, and now and then a few malformed or failed words.
   task automatic run_session(input int phase);
      int         roll, spread, cx, cy, cz;
      logic [1:0] act;
      roll   = $urandom_range(99);
      spread = 16 << (2 * phase);
      cx     = int'($urandom_range(4000)) - 2000;
      cy     = int'($urandom_range(4000)) - 2000;
      cz     = int'($urandom_range(4000)) - 2000;
      if (roll < 12) begin
         repeat ($urandom_range(1, 6)) begin
            act = 2'($urandom_range(3));
            // A successful calibration word at full range would pin the extremes for good.
            push_req(make_word(act, any16(), any16(), any16(),
                               (act == cch_pkg::ACT_CAL_SAMPLE) ? 1'b0 :
                                                                  1'($urandom_range(1))));
         end
      end else begin
         if (roll < 22) begin
            push_req(make_word(cch_pkg::ACT_RESTORE, any16(), any16(), any16(),
                               1'($urandom_range(1))));
         end else begin
            repeat ($urandom_range(2, 12))
               push_req(make_word(cch_pkg::ACT_CAL_SAMPLE, jitter_around(cx, spread),
                                  jitter_around(cy, spread), jitter_around(cz, spread),
                                  $urandom_range(99) < 90));
            push_req(make_word(cch_pkg::ACT_END_CAL, any16(), any16(), any16(),
                               1'($urandom_range(1))));
         end
         repeat ($urandom_range(3, 14)) begin
            if ($urandom_range(1))
               push_req(make_word(cch_pkg::ACT_HEADING, any16(), any16(), any16(),
                                  $urandom_range(99) < 92));
            else
               push_req(make_word(cch_pkg::ACT_HEADING, jitter_around(cx, 300),
                                  jitter_around(cy, 300), any16(), $urandom_range(99) < 92));
         end
      end
   endtask

   initial begin : stimulus
      int target;
      wait (!reset);

      // Headings against zero offsets, covering the quadrant folds and the field extremes.
      push_req(make_word(cch_pkg::ACT_HEADING, 0, 0, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 32767, -32768, 32767, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, -32768, -32768, -32768, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 0, -1, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, -1, -32768, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, -32768, 32767, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 123, 456, 789, 1'b0));
      // A failed calibration read must leave the extremes alone.
      push_req(make_word(cch_pkg::ACT_CAL_SAMPLE, 32767, -32768, 32767, 1'b0));
      // Ending calibration with no samples gives zero offsets, whatever read_ok says.
      push_req(make_word(cch_pkg::ACT_END_CAL, 0, 0, 0, 1'b0));
      push_req(make_word(cch_pkg::ACT_RESTORE, 0, 0, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_CAL_SAMPLE, 100, -200, 50, 1'b1));
      push_req(make_word(cch_pkg::ACT_CAL_SAMPLE, -301, 401, -7, 1'b1));
      push_req(make_word(cch_pkg::ACT_END_CAL, 0, 0, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 100, -200, 0, 1'b1));
      // Sample equal to the offsets, so the difference vector is zero.
      push_req(make_word(cch_pkg::ACT_HEADING, -100, 100, 0, 1'b1));

      write_settings(32767, -32768, -1, 1'b1);
      push_req(make_word(cch_pkg::ACT_RESTORE, 0, 0, 0, 1'b0));
      push_req(make_word(cch_pkg::ACT_HEADING, -32768, 32767, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 32767, -32768, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_RESTORE, 5, 5, 5, 1'b1));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            2:       write_settings(32767, -32768, -32768, 1'b1);
            5:       write_settings(-32768, 32767, 32767, 1'b1);
            default: write_settings(any16(), any16(), any16(), (phase % 3) != 1);
         endcase
         // The third phase opens with a long output hold so the block backs up and stalls.
         if (phase == 2) hold_output = 1'b1;
         jitter_on = (phase != 3);
         target    = sent + PHASE_WORDS;
         while (sent < target) run_session(phase);
      end

      // Full-range calibration last of all, since the extremes never narrow again.
      write_settings(-32768, 32767, 32767, 1'b1);
      push_req(make_word(cch_pkg::ACT_CAL_SAMPLE, 32767, -32768, 32767, 1'b1));
      push_req(make_word(cch_pkg::ACT_CAL_SAMPLE, -32768, 32767, -32768, 1'b1));
      push_req(make_word(cch_pkg::ACT_END_CAL, 0, 0, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 32767, 32767, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, -32768, -32768, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_HEADING, 0, 0, 0, 1'b1));
      push_req(make_word(cch_pkg::ACT_RESTORE, 0, 0, 0, 1'b0));
      push_req(make_word(cch_pkg::ACT_HEADING, 32767, -32768, 0, 1'b1));
      @(negedge clock);
      req_valid <= 1'b0;

      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/cch_pkg.sv
rtl/cch_front.sv
rtl/cch_queue.sv
rtl/cch_back.sv
rtl/compass_calibrate_and_heading.sv
tb/cch_status_checker.sv
tb/tb.sv
